FILE: rtl/core/miller_rabin_prime_test_macros.svh
// Assertion macros shared by the primality test RTL
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH

// same-cycle implication, clocked on clk_i, quiet in reset
`define MRPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, quiet in reset
`define MRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mrpt_pkg.sv
// Package with payload types and constants of the primality test
package mrpt_pkg;

  localparam int DefaultWidth = 63;
  localparam int FieldW       = 63;
  localparam int SmallMax     = 4;

  typedef struct packed {
    logic [FieldW-1:0] candidate;
    logic [FieldW-1:0] witness;
  } in_t;

  typedef struct packed {
    logic probably_prime;
    logic bad_witness;
  } out_t;

endpackage

FILE: rtl/core/mrpt_modmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle
module mrpt_modmul #(
  parameter int WIDTH = mrpt_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] p_o
);

  localparam int PW   = WIDTH + 3;
  localparam int CntW = $clog2(WIDTH + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [WIDTH-1:0] y_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] acc_d;
  logic [WIDTH-1:0] x_sel;
  logic [PW-1:0]    sum;
  logic [PW-1:0]    sub1;
  logic [PW-1:0]    sub2;

  always_comb begin
    x_sel = y_q[WIDTH-1] ? x_i : '0;
    sum   = {2'b00, acc_q, 1'b0} + {3'b000, x_sel};
    sub1  = sum - {3'b000, m_i};
    sub2  = sum - {2'b00, m_i, 1'b0};
    if (!sub2[PW-1]) begin
      acc_d = sub2[WIDTH-1:0];
    end else if (!sub1[PW-1]) begin
      acc_d = sub1[WIDTH-1:0];
    end else begin
      acc_d = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      y_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WIDTH);
        y_q    <= y_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        y_q   <= y_q << 1;
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

  `include "miller_rabin_prime_test_macros.svh"

  `MRPT_ASSERT_IMPL(mm_start_idle_a, start_i, !busy_q, "modmul started while busy")
  `MRPT_ASSERT_IMPL(mm_done_reduced_a, done_q, acc_q < m_i, "modmul result not reduced")
  `MRPT_ASSERT_NEXT(mm_last_step_a, busy_q && !start_i && cnt_q == CntW'(1), done_q,
                    "modmul missed done")

endmodule

FILE: rtl/core/miller_rabin_prime_test.sv
// Top level of the Miller-Rabin primality test, one round per transfer
//
//  channel | direction | payload           | handshake
//  in      | input     | mrpt_pkg::in_t    | in_valid_i / in_stall_o
//  out     | output    | mrpt_pkg::out_t   | out_valid_o / out_stall_i
//
// One item at a time. A candidate of 4 or less, or a bad witness, goes from the check
// state straight to the finish state. Otherwise skip steps shift n-1 to its leading bit,
// then each exponent bit takes a modular square and, for a one bit, a multiply, done by
// the bit-serial modular multiplier, one operand bit per cycle.
// No clearing pass after reset. A stalled result holds in the output register
// while the next item is already taken in.
module miller_rabin_prime_test #(
  parameter int WIDTH = mrpt_pkg::DefaultWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mrpt_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mrpt_pkg::out_t out_o
);

  localparam int InW  = (WIDTH < mrpt_pkg::FieldW) ? WIDTH : mrpt_pkg::FieldW;
  localparam int CntW = $clog2(WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SKIP,
    ST_DECIDE,
    ST_SQR,
    ST_MUL,
    ST_CHECKD,
    ST_LOOP,
    ST_SQ2,
    ST_FINISH
  } state_e;

  state_e         state_q;
  logic [WIDTH-1:0] n_q;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] x_q;
  logic [WIDTH-1:0] e_q;
  logic [CntW-1:0]  cnt_q;
  logic             mul_start_q;
  logic             mul_start_d;
  mrpt_pkg::out_t   res_q;
  mrpt_pkg::out_t   out_q;
  logic             out_valid_q;

  logic [WIDTH-1:0] n_m1;
  logic [WIDTH-1:0] n_m2;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] mul_p;
  logic             mul_done;
  logic             is_small;

  assign n_m1     = n_q - WIDTH'(1);
  assign n_m2     = n_q - WIDTH'(2);
  assign is_small = n_q <= WIDTH'(mrpt_pkg::SmallMax);
  assign mul_y    = (state_q == ST_MUL) ? a_q : x_q;

  always_comb begin
    mul_start_d = 1'b0;
    case (state_q)
      ST_DECIDE: mul_start_d = (e_q != '0);
      ST_SQR:    mul_start_d = mul_done && e_q[WIDTH-1];
      ST_LOOP:   mul_start_d = (cnt_q > CntW'(1));
      default:   mul_start_d = 1'b0;
    endcase
  end

  mrpt_modmul #(
    .WIDTH(WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .x_i    (x_q),
    .y_i    (mul_y),
    .m_i    (n_q),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      a_q         <= '0;
      x_q         <= '0;
      e_q         <= '0;
      cnt_q       <= '0;
      mul_start_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mul_start_q <= mul_start_d;
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q     <= WIDTH'(in_i.candidate[InW-1:0]);
            a_q     <= WIDTH'(in_i.witness[InW-1:0]);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          e_q   <= n_m1;
          cnt_q <= CntW'(WIDTH);
          if (is_small) begin
            res_q.probably_prime <= (n_q == WIDTH'(2)) || (n_q == WIDTH'(3));
            res_q.bad_witness    <= 1'b0;
            state_q              <= ST_FINISH;
          end else if ((a_q < WIDTH'(2)) || (a_q > n_m2)) begin
            res_q.probably_prime <= 1'b0;
            res_q.bad_witness    <= 1'b1;
            state_q              <= ST_FINISH;
          end else begin
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          e_q   <= e_q << 1;
          cnt_q <= cnt_q - CntW'(1);
          if (e_q[WIDTH-1]) begin
            x_q     <= a_q;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (e_q == '0) begin
            state_q <= ST_CHECKD;
          end else begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (mul_done) begin
            x_q <= mul_p;
            if (e_q[WIDTH-1]) begin
              state_q <= ST_MUL;
            end else begin
              e_q     <= e_q << 1;
              cnt_q   <= cnt_q - CntW'(1);
              state_q <= ST_DECIDE;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            x_q     <= mul_p;
            e_q     <= e_q << 1;
            cnt_q   <= cnt_q - CntW'(1);
            state_q <= ST_DECIDE;
          end
        end
        ST_CHECKD: begin
          res_q.bad_witness <= 1'b0;
          if ((x_q == WIDTH'(1)) || (x_q == n_m1)) begin
            res_q.probably_prime <= 1'b1;
            state_q              <= ST_FINISH;
          end else begin
            state_q <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (cnt_q <= CntW'(1)) begin
            res_q.probably_prime <= 1'b0;
            state_q              <= ST_FINISH;
          end else begin
            state_q <= ST_SQ2;
          end
        end
        ST_SQ2: begin
          if (mul_done) begin
            x_q   <= mul_p;
            cnt_q <= cnt_q - CntW'(1);
            if (mul_p == n_m1) begin
              res_q.probably_prime <= 1'b1;
              state_q              <= ST_FINISH;
            end else if (mul_p == WIDTH'(1)) begin
              res_q.probably_prime <= 1'b0;
              state_q              <= ST_FINISH;
            end else begin
              state_q <= ST_LOOP;
            end
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `include "miller_rabin_prime_test_macros.svh"

  `MRPT_ASSERT_IMPL(top_done_waits_a, mul_done,
                    state_q == ST_SQR || state_q == ST_MUL || state_q == ST_SQ2,
                    "multiplier done outside a multiply state")
  `MRPT_ASSERT_IMPL(top_verdict_excl_a, out_valid_o,
                    !(out_o.probably_prime && out_o.bad_witness),
                    "bad witness reported with prime verdict")
  `MRPT_ASSERT_NEXT(top_accept_check_a, in_valid_i && !in_stall_o, state_q == ST_CHECK,
                    "accepted transfer not checked")
  `MRPT_ASSERT_NEXT(top_finish_out_a, state_q == ST_FINISH && !out_stall_i, out_valid_o,
                    "finished verdict not presented")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Miller-Rabin primality test: directed table, then random rounds
module testbench;

  localparam int Width = mrpt_pkg::DefaultWidth;
  localparam int NumDirected = 22;
  localparam int NumRandom = 118;
  localparam int DrainCycles = 50;
  localparam longint unsigned CycleLimit = 64'd6_000_000;
  localparam logic [mrpt_pkg::FieldW-1:0] MaxField = '1;
  localparam logic [mrpt_pkg::FieldW-1:0] BigPrime = 63'd9223372036854775783;
  localparam logic [63:0] FieldSpan = 64'h8000_0000_0000_0000;

  localparam mrpt_pkg::out_t Composite  = 2'b00;
  localparam mrpt_pkg::out_t Prime      = 2'b10;
  localparam mrpt_pkg::out_t BadWitness = 2'b01;

  typedef struct packed {
    logic [mrpt_pkg::FieldW-1:0] candidate;
    logic [mrpt_pkg::FieldW-1:0] witness;
    logic                        typed;
    mrpt_pkg::out_t              verdict;
  } stim_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  mrpt_pkg::in_t  in_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  mrpt_pkg::out_t out_o;

  mrpt_pkg::out_t  verdict_q[$];
  stim_row_t       rows[NumDirected];
  int              mismatches = 0;
  int              sent = 0;
  int              received = 0;
  int              stall_left = 0;
  longint unsigned cycles = 0;

  miller_rabin_prime_test #(
    .WIDTH(Width)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] width_bits(logic [mrpt_pkg::FieldW-1:0] v);
    logic [63:0] mask;
    mask = (Width >= 64) ? '1 : ((64'd1 << Width) - 64'd1);
    return 64'(v) & mask;
  endfunction

  function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = (128'(x) * 128'(y)) % 128'(m);
    return prod[63:0];
  endfunction

  function automatic logic [63:0] mod_power(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_product(acc, b, m);
      b = mod_product(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic mrpt_pkg::out_t mr_verdict(mrpt_pkg::in_t item);
    logic [63:0]    n, a, last, d, x;
    int             r;
    int             i;
    mrpt_pkg::out_t v;
    v = Composite;
    n = width_bits(item.candidate);
    a = width_bits(item.witness);
    if (n <= mrpt_pkg::SmallMax) begin
      v.probably_prime = (n == 2 || n == 3);
    end else if (a < 2 || a > n - 2) begin
      v.bad_witness = 1'b1;
    end else begin
      last = n - 1;
      d = last;
      r = 0;
      while (!d[0]) begin
        d = d >> 1;
        r++;
      end
      x = mod_power(a, d, n);
      if (x == 1 || x == last) begin
        v.probably_prime = 1'b1;
      end else begin
        // stop one squaring short of a^(n-1)
        for (i = 1; i < r; i++) begin
          x = mod_product(x, x, n);
          if (x == last) begin
            v.probably_prime = 1'b1;
            break;
          end
          if (x == 1) break;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int draw_wait(int idx);
    return (idx % 32 >= 24) ? 0 : int'($urandom_range(0, 6));
  endfunction

  // primes first, then strong pseudoprimes to small bases
  function automatic logic [63:0] notable_candidate(int k);
    case (k)
      0:       return 64'd5;
      1:       return 64'd7;
      2:       return 64'd13;
      3:       return 64'd97;
      4:       return 64'd65537;
      5:       return 64'd998244353;
      6:       return 64'd1000000007;
      7:       return 64'd2147483647;
      8:       return 64'd4294967291;
      9:       return 64'd2305843009213693951;
      10:      return 64'd2047;
      11:      return 64'd1373653;
      12:      return 64'd25326001;
      13:      return 64'd3215031751;
      14:      return 64'd3474749660383;
      15:      return 64'd3825123056546413051;
      default: return 64'(BigPrime);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_verdict(mrpt_pkg::out_t got);
    mrpt_pkg::out_t want;
    received++;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no item pending", received));
      return;
    end
    want = verdict_q.pop_front();
    if (got.probably_prime !== want.probably_prime)
      report_mismatch($sformatf("result %0d probably_prime %b, want %b", received,
                                got.probably_prime, want.probably_prime));
    if (got.bad_witness !== want.bad_witness)
      report_mismatch($sformatf("result %0d bad_witness %b, want %b", received,
                                got.bad_witness, want.bad_witness));
  endtask

  task automatic send_item(input mrpt_pkg::in_t item, input logic typed,
                           input mrpt_pkg::out_t typed_verdict);
    int             gap;
    mrpt_pkg::out_t expect_v;
    gap = draw_wait(sent);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_i       <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expect_v  = typed ? typed_verdict : mr_verdict(item);
    verdict_q = {verdict_q, expect_v};
    sent++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_verdict(out_o);
        stall_left = draw_wait(received);
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    mrpt_pkg::in_t item;
    logic [63:0]   n, w;
    int            kind;
    int            k;
    int            len;

    rows[0]  = '{63'd0, 63'd0, 1'b1, Composite};
    rows[1]  = '{63'd1, MaxField, 1'b1, Composite};
    rows[2]  = '{63'd2, 63'd5, 1'b1, Prime};
    rows[3]  = '{63'd3, 63'd0, 1'b1, Prime};
    rows[4]  = '{63'd4, 63'd2, 1'b1, Composite};
    rows[5]  = '{63'd5, 63'd1, 1'b1, BadWitness};
    rows[6]  = '{63'd5, 63'd4, 1'b1, BadWitness};
    rows[7]  = '{63'd5, 63'd2, 1'b0, Composite};
    rows[8]  = '{63'd5, 63'd3, 1'b0, Composite};
    rows[9]  = '{MaxField, 63'd0, 1'b1, BadWitness};
    rows[10] = '{MaxField, MaxField, 1'b1, BadWitness};
    rows[11] = '{MaxField, 63'd2, 1'b0, Composite};
    rows[12] = '{BigPrime, 63'd2, 1'b0, Composite};
    rows[13] = '{BigPrime, BigPrime - 63'd2, 1'b0, Composite};
    rows[14] = '{63'd2047, 63'd2, 1'b0, Composite};
    rows[15] = '{63'd2047, 63'd3, 1'b0, Composite};
    rows[16] = '{63'd561, 63'd2, 1'b0, Composite};
    rows[17] = '{63'd2305843009213693951, 63'd3, 1'b0, Composite};
    rows[18] = '{63'd65537, 63'd3, 1'b0, Composite};
    rows[19] = '{63'd9, 63'd2, 1'b0, Composite};
    rows[20] = '{63'd25, 63'd7, 1'b0, Composite};
    rows[21] = '{63'd341, 63'd2, 1'b0, Composite};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NumDirected; k++) begin
      item.candidate = rows[k].candidate;
      item.witness   = rows[k].witness;
      send_item(item, rows[k].typed, rows[k].verdict);
    end

    for (k = 0; k < NumRandom; k++) begin
      kind = int'($urandom_range(0, 99));
      len = int'($urandom_range(3, 63));
      n = rand_word() >> (64 - len);
      if ($urandom_range(0, 1)) n[0] = 1'b1;
      if (n <= mrpt_pkg::SmallMax) n = n + 64'd5;
      w = 64'd2 + rand_word() % (n - 64'd3);
      if (kind < 50) begin
        n = notable_candidate(int'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) w = 64'($urandom_range(2, 7));
        else w = 64'd2 + rand_word() % (n - 64'd3);
      end else if (kind < 72) begin
        // well-formed round on an arbitrary candidate
      end else if (kind < 82) begin
        if ($urandom_range(0, 1)) w = 64'($urandom_range(0, 1));
        else w = (n - 64'd1) + rand_word() % (FieldSpan - (n - 64'd1));
      end else if (kind < 92) begin
        n = 64'($urandom_range(0, mrpt_pkg::SmallMax));
        w = rand_word();
      end else begin
        n = rand_word();
        w = rand_word();
      end
      item.candidate = n[mrpt_pkg::FieldW-1:0];
      item.witness   = w[mrpt_pkg::FieldW-1:0];
      send_item(item, 1'b0, Composite);
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
